// ===== hdl/tlfr_pkg.sv =====
package tlfr_pkg;

   // Widths of the level and of the fraction done
   localparam int LEVEL_BITS    = 16;
   localparam int FRACTION_BITS = 16;
   localparam int FRAC_W        = FRACTION_BITS + 1;

   localparam int TIME_BITS = 32;
   localparam int DUR_BITS  = 31;
   localparam int CSR_BITS  = 16;

   // Long division of {elapsed, FRACTION_BITS zeros} by the duration
   localparam int DIV_BITS = DUR_BITS + FRACTION_BITS;
   localparam int REM_W    = DUR_BITS + 1;
   localparam int CNT_W    = $clog2(DIV_BITS);

   localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   // Register map
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CEILING      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_INTERVAL = 2'd1;
   localparam logic [CSR_BITS-1:0]     CEILING_RESET    = 16'd255;

   // Item commands
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_FADE   = 1'b1;

   typedef struct packed {
      logic                  command;
      logic [TIME_BITS-1:0]  now_ms;
      logic [LEVEL_BITS-1:0] target_level;
      logic [DUR_BITS-1:0]   duration_ms;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  fading;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_step;
      logic add;
      logic mul;
      logic lvl;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_fade;
      logic do_div;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/timed_linear_fade_ramp.sv =====
// Channel   Direction  Ports                              Carries
// request   in         req_valid, req_ready, req_data     fade command or time update
// response  out        rsp_valid, rsp_ready, rsp_data     level and fading flag
// csr       in         csr_valid, csr_ready, csr_index,   level ceiling, minimum
//                      csr_wdata                          update interval
//
// A time update that advances the fraction passes, from one request transfer
// to the next, through the idle state that takes the request, a preparation
// state, the bit-serial restoring divider that forms elapsed / duration from
// the DIV_BITS (47) bits of the numerator, the add, multiply and level states,
// and a last state that loads the response register. An update that does not
// advance skips the divider; a fade command only takes, prepares and loads.
// Synchronous active-high reset clears all fade state and restores the
// register reset values. A stalled response holds in its register; the
// controller waits in its last state until that register is free.
module timed_linear_fade_ramp import tlfr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Registers must be written only while idle (not enforced here), so take every csr transfer at once
   assign csr_ready = 1'b1;

   // Sequence the phases of one item
   tlfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Hold the fade state, divide, multiply, clamp and register the response
   tlfr_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== hdl/tlfr_ctrl.sv =====
module tlfr_ctrl import tlfr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_LVL  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            if (status.is_fade) begin
               state_in = ST_DONE;
            end else if (status.do_div) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_LVL;
         end
         ST_LVL: begin
            cmd.lvl  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/tlfr_dpath.sv =====
module tlfr_dpath import tlfr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  req_type                 req_data,
   input  logic                    csr_valid,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  cmd_type                 cmd,
   output status_type              status
);

   localparam int PROD_W = LEVEL_BITS + FRAC_W;
   localparam int LVL_W  = LEVEL_BITS + 2;

   req_type                 item_ff, item_in;
   logic [CSR_BITS-1:0]     ceil_ff, ceil_in;
   logic [CSR_BITS-1:0]     minint_ff, minint_in;
   logic [LEVEL_BITS-1:0]   cur_ff, cur_in;
   logic [LEVEL_BITS-1:0]   start_ff, start_in;
   logic [LEVEL_BITS-1:0]   goal_ff, goal_in;
   logic [LEVEL_BITS-1:0]   dist_ff, dist_in;
   logic                    down_ff, down_in;
   logic [FRAC_W-1:0]       frac_ff, frac_in;
   logic [DUR_BITS-1:0]     dur_ff, dur_in;
   logic [TIME_BITS-1:0]    last_ff, last_in;
   logic                    prog_ff, prog_in;
   logic [DIV_BITS-1:0]     num_ff, num_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [FRAC_W-1:0]       quo_ff, quo_in;
   logic                    ovf_ff, ovf_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [TIME_BITS-1:0]    diff;
   logic                    backward;
   logic [DUR_BITS-1:0]     elapsed;
   logic                    dur_zero;
   logic [REM_W-1:0]        trial;
   logic                    fits;
   logic [FRAC_W:0]         sum;
   logic                    sat;
   logic [LEVEL_BITS:0]     step;
   logic [LVL_W-1:0]        lvl;
   logic [LEVEL_BITS-1:0]   target;

   // Elapsed time, zero when the clock went backward
   assign diff     = item_ff.now_ms - last_ff;
   assign backward = diff[TIME_BITS-1];
   assign elapsed  = backward ? '0 : diff[DUR_BITS-1:0];
   assign dur_zero = (dur_ff == '0);
   assign target   = item_ff.target_level;

   assign trial = {rem_ff[REM_W-2:0], num_ff[DIV_BITS-1]};
   assign fits  = (trial >= REM_W'(dur_ff));

   assign sum = {1'b0, frac_ff} + {1'b0, quo_ff};
   assign sat = ovf_ff || (sum >= {1'b0, FRAC_ONE});

   assign step = prod_ff[FRACTION_BITS +: LEVEL_BITS + 1];
   assign lvl  = down_ff ? ({2'b00, start_ff} - {1'b0, step})
                         : ({2'b00, start_ff} + {1'b0, step});

   assign status.is_fade  = (item_ff.command == CMD_FADE);
   assign status.do_div   = !dur_zero && (elapsed > DUR_BITS'(minint_ff));
   assign status.div_last = (cnt_ff == CNT_W'(DIV_BITS - 1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      item_in      = item_ff;
      ceil_in      = ceil_ff;
      minint_in    = minint_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      goal_in      = goal_ff;
      dist_in      = dist_ff;
      down_in      = down_ff;
      frac_in      = frac_ff;
      dur_in       = dur_ff;
      last_in      = last_ff;
      prog_in      = prog_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         if (csr_index == CSR_CEILING) begin
            ceil_in = csr_wdata;
         end else if (csr_index == CSR_MIN_INTERVAL) begin
            minint_in = csr_wdata;
         end
      end

      if (cmd.load) begin
         item_in = req_data;
      end

      if (cmd.prep) begin
         if (item_ff.command == CMD_FADE) begin
            // New fade: restart the fraction only for a new target
            if (target != goal_ff) begin
               frac_in = '0;
            end
            start_in = cur_ff;
            goal_in  = target;
            dur_in   = item_ff.duration_ms;
            down_in  = (cur_ff > target);
            dist_in  = (cur_ff > target) ? (cur_ff - target) : (target - cur_ff);
            prog_in  = 1'b1;
         end else begin
            if (backward || dur_zero || status.do_div) begin
               last_in = item_ff.now_ms;
            end
            if (dur_zero) begin
               frac_in = FRAC_ONE;
               prog_in = 1'b0;
            end
            num_in = {elapsed, {FRACTION_BITS{1'b0}}};
            rem_in = '0;
            quo_in = '0;
            ovf_in = 1'b0;
            cnt_in = '0;
         end
      end

      if (cmd.div_step) begin
         rem_in = fits ? (trial - REM_W'(dur_ff)) : trial;
         num_in = {num_ff[DIV_BITS-2:0], 1'b0};
         quo_in = {quo_ff[FRAC_W-2:0], fits};
         ovf_in = ovf_ff | quo_ff[FRAC_W-1];
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.add) begin
         frac_in = sat ? FRAC_ONE : sum[FRAC_W-1:0];
         if (sat) begin
            prog_in = 1'b0;
         end
      end

      if (cmd.mul) begin
         prod_in = PROD_W'(dist_ff) * PROD_W'(frac_ff);
      end

      if (cmd.lvl) begin
         if (lvl[LVL_W-1]) begin
            cur_in  = '0;
            prog_in = 1'b0;
         end else if (lvl > LVL_W'(ceil_ff)) begin
            cur_in  = LEVEL_BITS'(ceil_ff);
            prog_in = 1'b0;
         end else begin
            cur_in = lvl[LEVEL_BITS-1:0];
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in.level  = cur_ff;
         rsp_data_in.fading = prog_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ceil_ff      <= CEILING_RESET;
         minint_ff    <= '0;
         cur_ff       <= '0;
         start_ff     <= '0;
         goal_ff      <= '0;
         dist_ff      <= '0;
         down_ff      <= 1'b0;
         frac_ff      <= '0;
         dur_ff       <= '0;
         last_ff      <= '0;
         prog_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ceil_ff      <= ceil_in;
         minint_ff    <= minint_in;
         cur_ff       <= cur_in;
         start_ff     <= start_in;
         goal_ff      <= goal_in;
         dist_ff      <= dist_in;
         down_ff      <= down_in;
         frac_ff      <= frac_in;
         dur_ff       <= dur_in;
         last_ff      <= last_in;
         prog_ff      <= prog_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      ovf_ff      <= ovf_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
